### hw/rtl/mooc_pkg.sv
`timescale 1ns / 1ps

package mooc_pkg;

  localparam int ADC_BITS_DEFAULT = 10;

  localparam int SENSE_W    = 10;
  localparam int SCREEN_W   = 16;
  localparam int SETPOINT_W = 7;
  localparam int SEG_W      = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SENSE_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_TIMEOUT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX   = 8'd3;

  localparam logic [SENSE_W-1:0]    SENSE_INTERVAL_RST = 10'd50;
  localparam logic [SCREEN_W-1:0]   SCREEN_TIMEOUT_RST = 16'd500;
  localparam logic [SETPOINT_W-1:0] SETPOINT_MIN_RST   = 7'd5;
  localparam logic [SETPOINT_W-1:0] SETPOINT_MAX_RST   = 7'd99;
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST       = 7'd85;

  localparam logic [6:0] PERCENT_SCALE = 7'd100;

  typedef struct packed {
    logic [SENSE_W-1:0]    sense_interval;
    logic [SCREEN_W-1:0]   screen_timeout;
    logic [SETPOINT_W-1:0] setpoint_min;
    logic [SETPOINT_W-1:0] setpoint_max;
  } cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0]      seg_tens;
    logic [SEG_W-1:0]      seg_ones;
    logic [SETPOINT_W-1:0] moisture_percent;
    logic [SETPOINT_W-1:0] setpoint;
    logic                  screen_on;
    logic                  pump_on;
  } res_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

  // Quotient by ten through a reciprocal; exact for every seven-bit value.
  function automatic logic [3:0] div10(input logic [SETPOINT_W-1:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

### hw/rtl/moisture_on_off_controller.sv
`timescale 1ns / 1ps

// On/off moisture controller with a button-driven setpoint and a screen timer.
// Items enter on the s_axis channel: tuser carries the item kind (low for a
// button event, high for a timer tick), tdata the button levels and the
// converter sample. Each accepted item yields exactly one result item on the
// m_axis channel with the pump and screen flags, the setpoint, the last
// moisture reading and the seven-segment codes of the setpoint digits.
// An accepted item is held in the input register and moves to the output
// register when that is free or being taken, where its result is presented.
// One item is taken every cycle while the receiver takes each result; the
// state update between the two registers is combinational. When
// the receiver stalls, the result waits in the output register while one
// further item is held in the input register; s_axis_tready then falls until
// the output is taken. Configuration writes on the cfg channel are always
// accepted and should only be issued while no item is in flight.
// Synchronous reset restores the register defaults, sets the setpoint to 85,
// the pump off, the screen on, clears the counters and empties both registers.

module moisture_on_off_controller #(
  parameter int ADC_BITS = mooc_pkg::ADC_BITS_DEFAULT,
  localparam int IN_W = ((3 + ADC_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: btn_up, btn_down, btn_toggle, adc_sample
  input  logic [IN_W-1:0]                   s_axis_tdata,
  // tuser: action
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: pump_on, screen_on, setpoint, moisture_percent, seg_ones, seg_tens
  output logic [mooc_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mooc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mooc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mooc_pkg::*;

  cfg_t cfg;
  res_t res;

  logic                in_valid;
  logic                in_action;
  logic                in_up;
  logic                in_down;
  logic                in_toggle;
  logic [ADC_BITS-1:0] in_sample;
  logic                step;
  res_t                out_data;

  assign cfg_ready     = 1'b1;
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  mooc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser[0];
      in_up     <= s_axis_tdata[0];
      in_down   <= s_axis_tdata[1];
      in_toggle <= s_axis_tdata[2];
      in_sample <= s_axis_tdata[ADC_BITS+2:3];
    end
  end

  mooc_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (step),
    .action     (in_action),
    .btn_up     (in_up),
    .btn_down   (in_down),
    .btn_toggle (in_toggle),
    .adc_sample (in_sample),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

  assign m_axis_tdata = {{(OUT_W - $bits(res_t)){1'b0}}, out_data};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("pending result dropped");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both registers are full");

endmodule

### hw/rtl/mooc_cfg.sv
`timescale 1ns / 1ps

module mooc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [mooc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [mooc_pkg::CFG_DATA_W-1:0]     wr_data,
  output mooc_pkg::cfg_t                      cfg
);
  import mooc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sense_interval <= SENSE_INTERVAL_RST;
      cfg.screen_timeout <= SCREEN_TIMEOUT_RST;
      cfg.setpoint_min   <= SETPOINT_MIN_RST;
      cfg.setpoint_max   <= SETPOINT_MAX_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SENSE_INTERVAL: cfg.sense_interval <= wr_data[SENSE_W-1:0];
        REG_SCREEN_TIMEOUT: cfg.screen_timeout <= wr_data[SCREEN_W-1:0];
        REG_SETPOINT_MIN:   cfg.setpoint_min   <= wr_data[SETPOINT_W-1:0];
        REG_SETPOINT_MAX:   cfg.setpoint_max   <= wr_data[SETPOINT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/mooc_core.sv
`timescale 1ns / 1ps

module mooc_core #(
  parameter int ADC_BITS = mooc_pkg::ADC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mooc_pkg::cfg_t       cfg,
  input  logic                 step,
  input  logic                 action,
  input  logic                 btn_up,
  input  logic                 btn_down,
  input  logic                 btn_toggle,
  input  logic [ADC_BITS-1:0]  adc_sample,
  output mooc_pkg::res_t       res
);
  import mooc_pkg::*;

  logic [SETPOINT_W-1:0] setpoint_reg, setpoint_next;
  logic                  pump_reg, pump_next;
  logic                  screen_reg, screen_next;
  logic [SENSE_W-1:0]    sense_count, sense_count_next;
  logic [SCREEN_W-1:0]   screen_count, screen_count_next;
  logic [SETPOINT_W-1:0] moisture_reg, moisture_next;

  logic [SETPOINT_W-1:0] sp_up;
  logic [SENSE_W-1:0]    sense_inc;
  logic [SCREEN_W-1:0]   screen_inc;
  logic [ADC_BITS+6:0]   product;
  logic [SETPOINT_W-1:0] percent;
  logic [3:0]            tens_q;
  logic [3:0]            tens_digit;
  logic [3:0]            ones_digit;

  assign sense_inc  = sense_count + 1'b1;
  assign screen_inc = screen_count + 1'b1;
  assign product    = {7'd0, adc_sample} * {{ADC_BITS{1'b0}}, PERCENT_SCALE};
  assign percent    = product[ADC_BITS+6:ADC_BITS];
  assign sp_up      = (btn_up && setpoint_reg < cfg.setpoint_max) ?
                      setpoint_reg + 1'b1 : setpoint_reg;

  always_comb begin
    setpoint_next     = setpoint_reg;
    pump_next         = pump_reg;
    screen_next       = screen_reg;
    sense_count_next  = sense_count;
    screen_count_next = screen_count;
    moisture_next     = moisture_reg;
    if (!action) begin
      screen_next = 1'b1;
      setpoint_next = (btn_down && sp_up > cfg.setpoint_min) ? sp_up - 1'b1 : sp_up;
      if (btn_toggle) begin
        pump_next = !pump_reg;
      end
    end else begin
      sense_count_next  = sense_inc;
      screen_count_next = screen_inc;
      if (sense_inc >= cfg.sense_interval) begin
        sense_count_next = '0;
        moisture_next    = percent;
        if (percent < setpoint_reg) begin
          pump_next = 1'b1;
        end else if (percent > setpoint_reg) begin
          pump_next = 1'b0;
        end
      end
      if (screen_inc >= cfg.screen_timeout) begin
        screen_count_next = '0;
        screen_next       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_reg <= SETPOINT_RST;
      pump_reg     <= 1'b0;
      screen_reg   <= 1'b1;
      sense_count  <= '0;
      screen_count <= '0;
      moisture_reg <= '0;
    end else if (step) begin
      setpoint_reg <= setpoint_next;
      pump_reg     <= pump_next;
      screen_reg   <= screen_next;
      sense_count  <= sense_count_next;
      screen_count <= screen_count_next;
      moisture_reg <= moisture_next;
    end
  end

  always_comb begin
    tens_q     = div10(setpoint_next);
    tens_digit = (tens_q >= 4'd10) ? tens_q - 4'd10 : tens_q;
    ones_digit = 4'(setpoint_next - {tens_q, 3'd0} - {2'd0, tens_q, 1'b0});
  end

  assign res.pump_on          = pump_next;
  assign res.screen_on        = screen_next;
  assign res.setpoint         = setpoint_next;
  assign res.moisture_percent = moisture_next;
  assign res.seg_ones         = seg_code(ones_digit);
  assign res.seg_tens         = seg_code(tens_digit);

  a_setpoint_hold: assert property (@(posedge clk) disable iff (rst)
    !step || action |=> $stable(setpoint_reg))
    else $error("setpoint moved without a button item");

  a_screen_wake: assert property (@(posedge clk) disable iff (rst)
    step && !action |=> screen_reg)
    else $error("screen not woken by a button item");

  a_moisture_hold: assert property (@(posedge clk) disable iff (rst)
    !(step && action) |=> $stable(moisture_reg))
    else $error("moisture changed outside a tick");

  a_setpoint_limits: assert property (@(posedge clk) disable iff (rst)
    step && !action && $stable(cfg) && setpoint_reg >= cfg.setpoint_min &&
    setpoint_reg <= cfg.setpoint_max |=>
    setpoint_reg >= cfg.setpoint_min && setpoint_reg <= cfg.setpoint_max)
    else $error("setpoint left its limits");

endmodule

### test/moisture_on_off_checker.sv
`timescale 1ns / 1ps

module moisture_on_off_checker #(
  parameter int   IN_W     = 16,
  parameter logic ACT_TICK = 1'b1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_ready,
  input  logic [IN_W-1:0]                   item_data,
  input  logic [0:0]                        item_kind,
  input  logic                              status_valid,
  input  logic                              status_ready,
  input  logic [mooc_pkg::OUT_W-1:0]        status_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mooc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mooc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                outstanding,
  output int                                failures
);
  import mooc_pkg::*;

  localparam int RES_W       = $bits(res_t);
  localparam int MAX_REPORTS = 100;
  localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic [SENSE_W-1:0]    sense_limit;
  logic [SCREEN_W-1:0]   screen_limit;
  logic [SETPOINT_W-1:0] floor_sp;
  logic [SETPOINT_W-1:0] ceil_sp;
  logic [SETPOINT_W-1:0] setpoint;
  logic                  pump;
  logic                  screen;
  logic [SENSE_W-1:0]    sense_ticks;
  logic [SCREEN_W-1:0]   screen_ticks;
  logic [SETPOINT_W-1:0] moisture;
  res_t                  expected_status [$];
  res_t                  got;
  res_t                  want;
  int                    mismatches = 0;
  int                    result_no = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] seen,
                             input logic [15:0] wanted);
    if (seen !== wanted) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                result_no, name, seen, wanted));
    end
  endtask

  // Advances the controller state by one item and queues the status it leaves.
  task automatic step_controller(input logic kind, input logic [IN_W-1:0] data);
    logic                 up;
    logic                 down;
    logic                 toggle;
    logic [9:0]           sample;
    logic [16:0]          scaled;
    res_t                 r;
    up     = data[0];
    down   = data[1];
    toggle = data[2];
    sample = data[12:3];
    if (kind != ACT_TICK) begin
      screen = 1'b1;
      if (up && setpoint < ceil_sp) begin
        setpoint = setpoint + 1'b1;
      end
      if (down && setpoint > floor_sp) begin
        setpoint = setpoint - 1'b1;
      end
      if (toggle) begin
        pump = !pump;
      end
    end else begin
      sense_ticks  = sense_ticks + 1'b1;
      screen_ticks = screen_ticks + 1'b1;
      if (sense_ticks >= sense_limit) begin
        sense_ticks = '0;
        scaled      = 17'(sample) * 17'd100;
        moisture    = scaled[16:10];
        if (moisture < setpoint) begin
          pump = 1'b1;
        end else if (moisture > setpoint) begin
          pump = 1'b0;
        end
      end
      if (screen_ticks >= screen_limit) begin
        screen_ticks = '0;
        screen       = 1'b0;
      end
    end
    r.pump_on          = pump;
    r.screen_on        = screen;
    r.setpoint         = setpoint;
    r.moisture_percent = moisture;
    r.seg_ones         = DIGIT_GLYPH[setpoint % 10];
    r.seg_tens         = DIGIT_GLYPH[(setpoint / 10) % 10];
    expected_status.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sense_limit  = SENSE_INTERVAL_RST;
      screen_limit = SCREEN_TIMEOUT_RST;
      floor_sp     = SETPOINT_MIN_RST;
      ceil_sp      = SETPOINT_MAX_RST;
      setpoint     = SETPOINT_RST;
      pump         = 1'b0;
      screen       = 1'b1;
      sense_ticks  = '0;
      screen_ticks = '0;
      moisture     = '0;
      expected_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENSE_INTERVAL: sense_limit  = cfg_data[SENSE_W-1:0];
          REG_SCREEN_TIMEOUT: screen_limit = cfg_data[SCREEN_W-1:0];
          REG_SETPOINT_MIN:   floor_sp     = cfg_data[SETPOINT_W-1:0];
          REG_SETPOINT_MAX:   ceil_sp      = cfg_data[SETPOINT_W-1:0];
          default: ;
        endcase
      end
      if (status_valid && status_ready) begin
        result_no++;
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_no));
        end else begin
          want = expected_status.pop_front();
          got  = res_t'(status_data[RES_W-1:0]);
          check_field("pump_on", 16'(got.pump_on), 16'(want.pump_on));
          check_field("screen_on", 16'(got.screen_on), 16'(want.screen_on));
          check_field("setpoint", 16'(got.setpoint), 16'(want.setpoint));
          check_field("moisture_percent", 16'(got.moisture_percent),
                      16'(want.moisture_percent));
          check_field("seg_ones", 16'(got.seg_ones), 16'(want.seg_ones));
          check_field("seg_tens", 16'(got.seg_tens), 16'(want.seg_tens));
          check_field("padding", 16'(status_data[OUT_W-1:RES_W]), 16'd0);
        end
      end
      if (item_valid && item_ready) begin
        step_controller(item_kind[0], item_data);
      end
    end
    outstanding <= expected_status.size();
    failures    <= mismatches;
  end

endmodule

### test/moisture_on_off_controller_tb.sv
`timescale 1ns / 1ps

module moisture_on_off_controller_tb;
  import mooc_pkg::*;

  localparam int   IN_W              = ((3 + ADC_BITS_DEFAULT + 7) / 8) * 8;
  localparam logic ACT_BUTTON        = 1'b0;
  localparam logic ACT_TICK          = 1'b1;
  localparam int   STALL_LIMIT       = 2000;
  localparam int   ITEMS_PER_SETTING = 160;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    outstanding;
  int                    failures;
  int                    send_gap_pct = 7;
  int                    take_gap_pct = 59;

  moisture_on_off_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  moisture_on_off_checker #(
    .IN_W     (IN_W),
    .ACT_TICK (ACT_TICK)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s_axis_tvalid),
    .item_ready   (s_axis_tready),
    .item_data    (s_axis_tdata),
    .item_kind    (s_axis_tuser),
    .status_valid (m_axis_tvalid),
    .status_ready (m_axis_tready),
    .status_data  (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .failures     (failures)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("moisture_on_off_controller test failed");
    $finish;
  end

  task automatic send_item(input logic kind, input logic up, input logic down,
                           input logic toggle, input logic [9:0] sample);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_W'({sample, toggle, down, up});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic press(input logic up, input logic down, input logic toggle);
    send_item(ACT_BUTTON, up, down, toggle, '0);
  endtask

  task automatic tick(input logic [9:0] sample);
    send_item(ACT_TICK, 1'b0, 1'b0, 1'b0, sample);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_settings(input logic [SENSE_W-1:0] interval,
                                input logic [SCREEN_W-1:0] timeout,
                                input logic [SETPOINT_W-1:0] lo,
                                input logic [SETPOINT_W-1:0] hi);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{REG_SENSE_INTERVAL, REG_SCREEN_TIMEOUT, REG_SETPOINT_MIN, REG_SETPOINT_MAX};
    vals = '{CFG_DATA_W'(interval), CFG_DATA_W'(timeout), CFG_DATA_W'(lo), CFG_DATA_W'(hi)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         up_pct;
    logic       kind;
    logic [9:0] sample;
    logic [6:0] lo;
    up_pct = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Setpoint pinned between its limits, then pump decisions below, above and at it.
    write_settings(10'd2, 16'd65535, 7'd84, 7'd86);
    press(1'b1, 1'b0, 1'b0);
    press(1'b1, 1'b0, 1'b0);
    press(1'b1, 1'b1, 1'b0);
    press(1'b0, 1'b1, 1'b0);
    press(1'b0, 1'b1, 1'b0);
    press(1'b0, 1'b0, 1'b0);
    press(1'b0, 1'b0, 1'b1);
    tick(10'd1023);
    tick(10'd1023);
    tick('0);
    tick('0);
    tick(10'd861);
    tick(10'd861);
    press(1'b0, 1'b0, 1'b1);
    tick(10'd861);
    tick(10'd861);
    hold_until_drained();

    write_settings(10'd1023, 16'd1, 7'd0, 7'd127);
    tick(10'd512);
    tick(10'd512);
    tick(10'd512);
    press(1'b0, 1'b0, 1'b0);
    hold_until_drained();

    // Limits cut below the running counts, down to zero, so both fire on every tick.
    write_settings(10'd0, 16'd0, 7'd0, 7'd127);
    tick(10'd1023);
    tick('0);
    hold_until_drained();

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 7 : (mode == 1) ? 59 : 0;
      take_gap_pct = (mode == 0) ? 59 : (mode == 1) ? 7 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: write_settings(SENSE_INTERVAL_RST, SCREEN_TIMEOUT_RST, SETPOINT_MIN_RST,
                            SETPOINT_MAX_RST);
          1: write_settings(10'd1, 16'd1, 7'd0, 7'd127);
          2: write_settings(10'd1023, 16'd65535, 7'd99, 7'd99);
          default: begin
            lo = 7'($urandom_range(60));
            write_settings(10'($urandom_range(1, 8)), 16'($urandom_range(1, 40)), lo,
                           7'($urandom_range(99, lo)));
          end
        endcase
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          if (n % 40 == 0) begin
            up_pct = 15 + 35 * $urandom_range(2);
          end
          kind = ($urandom_range(1) == 0) ? ACT_BUTTON : ACT_TICK;
          case ($urandom_range(9))
            0:       sample = '0;
            1:       sample = '1;
            default: sample = 10'($urandom_range(1023));
          endcase
          send_item(kind, $urandom_range(99) < up_pct, $urandom_range(99) < 100 - up_pct,
                    $urandom_range(7) == 0, sample);
        end
        hold_until_drained();
      end
    end

    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("moisture_on_off_controller test passed");
    end else begin
      $display("moisture_on_off_controller test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mooc_pkg.sv
hw/rtl/mooc_cfg.sv
hw/rtl/mooc_core.sv
hw/rtl/moisture_on_off_controller.sv
test/moisture_on_off_checker.sv
test/moisture_on_off_controller_tb.sv
